// File: design/pse_pkg.sv
// Shared constants, codes and control structs for the postfix stack evaluator.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package pse_pkg;

  // Datapath and stack sizing
  localparam int DATA_WIDTH  = 64;
  localparam int STACK_DEPTH = 16;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Fixed field widths of the channels
  localparam int MODE_W   = 4;
  localparam int LIT_W    = 64;
  localparam int DEPTH_W  = 5;
  localparam int STATUS_W = 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [MODE_W-1:0]     mode_t;
  typedef logic [STATUS_W-1:0]   status_t;

  // Token kinds
  localparam mode_t MODE_LITERAL = 4'd0;
  localparam mode_t MODE_EQ      = 4'd1;
  localparam mode_t MODE_AND     = 4'd2;
  localparam mode_t MODE_OR      = 4'd3;
  localparam mode_t MODE_NOT     = 4'd4;
  localparam mode_t MODE_ADD     = 4'd5;
  localparam mode_t MODE_SUB     = 4'd6;
  localparam mode_t MODE_MUL     = 4'd7;
  localparam mode_t MODE_DIV     = 4'd8;
  localparam mode_t MODE_MOD     = 4'd9;
  localparam mode_t MODE_UNKNOWN = 4'd10;

  // Result status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UNDER   = 2'd1;
  localparam status_t ST_OVER    = 2'd2;
  localparam status_t ST_DIVZERO = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture the accepted token
    logic rd_a;       // read the entry below the top
    logic exec;       // register the single-cycle result
    logic mul_start;
    logic div_start;
    logic take_mul;
    logic take_div;
    logic commit;     // update stack and load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic use_mul;
    logic use_div;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

endpackage

// File: design/pse_if.sv
// Valid/ready channel interfaces for tokens in and results out.
// Depends on pse_pkg for field widths.
`timescale 1ns / 1ps

interface pse_token_if import pse_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LIT_W-1:0]  literal_value;
  logic              last_token;

  modport source (output valid, output mode, output literal_value, output last_token,
                  input ready);
  modport sink (input valid, input mode, input literal_value, input last_token,
                output ready);
endinterface

interface pse_result_if import pse_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LIT_W-1:0]    top_value;
  logic [DEPTH_W-1:0]  stack_depth;
  logic [STATUS_W-1:0] status;
  logic                expression_done;

  modport source (output valid, output top_value, output stack_depth, output status,
                  output expression_done, input ready);
  modport sink (input valid, input top_value, input stack_depth, input status,
                input expression_done, output ready);
endinterface

// File: design/pse_mul.sv
// Low-half product of two DATA_WIDTH operands from three half-width multiplies.
// One shared multiplier and a registered product. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_mul import pse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  data_t a,
  input  data_t b,
  output data_t product,
  output logic  done
);

  localparam int HALF   = (DATA_WIDTH + 1) / 2;
  localparam int PROD_W = 2 * HALF;

  logic            busy;
  logic [1:0]      cnt;
  data_t           a_r;
  data_t           b_r;
  logic [PROD_W-1:0] prod;
  data_t           acc;
  logic [HALF-1:0] mx;
  logic [HALF-1:0] my;
  data_t           prod_lo;
  data_t           prod_sh;

  // Select the half operands for this step
  always_comb begin
    mx = (cnt == 2'd2) ? HALF'(a_r[DATA_WIDTH-1:HALF]) : a_r[HALF-1:0];
    my = (cnt == 2'd1) ? HALF'(b_r[DATA_WIDTH-1:HALF]) : b_r[HALF-1:0];
    prod_lo = prod[DATA_WIDTH-1:0];
    prod_sh = prod_lo << HALF;
  end

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Multiply, then accumulate the shifted cross terms
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      prod <= PROD_W'(mx) * PROD_W'(my);
      case (cnt)
        2'd1:    acc <= prod_lo;
        2'd2:    acc <= acc + prod_sh;
        2'd3:    acc <= acc + prod_sh;
        default: acc <= acc;
      endcase
    end
  end

  assign product = acc;

endmodule

// File: design/pse_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Gives quotient and remainder when done is raised. Uses pse_pkg.
`timescale 1ns / 1ps

module pse_div import pse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  data_t dividend,
  input  data_t divisor,
  output data_t quotient,
  output data_t remainder,
  output logic  done
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  data_t               rem;
  data_t               quo;
  data_t               den;
  logic [DATA_WIDTH:0] rem_sh;
  logic [DATA_WIDTH:0] diff;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh = {rem, quo[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, den};
  end

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      if (!diff[DATA_WIDTH]) begin
        rem <= diff[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DATA_WIDTH-1:0];
        quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// File: design/pse_dp.sv
// Evaluator datapath: operand stack memory, stack pointer, top register, ALU,
// output register. Instantiates pse_mul and pse_div; uses pse_pkg.
`timescale 1ns / 1ps

module pse_dp import pse_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output dp_stat_t            stat,
  input  logic [MODE_W-1:0]   mode,
  input  logic [LIT_W-1:0]    literal_value,
  input  logic                last_token,
  output logic [LIT_W-1:0]    top_value,
  output logic [DEPTH_W-1:0]  stack_depth,
  output logic [STATUS_W-1:0] status,
  output logic                expression_done
);

  data_t            mem [STACK_DEPTH];
  data_t            rdata;
  logic [SP_W-1:0]  sp;
  data_t            top;
  mode_t            mode_r;
  data_t            lit_r;
  logic             last_r;
  data_t            res;

  logic             is_bin;
  logic             is_not;
  logic             is_push;
  logic             under;
  logic             over;
  logic             divzero;
  status_t          st;
  logic             ok;
  logic [SP_W-1:0]  sp_m1;
  logic [SP_W-1:0]  sp_m2;
  logic [SP_W-1:0]  sp_new;
  logic [IDX_W-1:0] wr_idx;
  data_t            alu;
  data_t            top_new;
  data_t            mul_p;
  logic             mul_done;
  data_t            div_q;
  data_t            div_r;
  logic             div_done;

  // Cut the literal to the datapath width
  function automatic data_t lit_r_in(input logic [LIT_W-1:0] v);
    lit_r_in = v[DATA_WIDTH-1:0];
  endfunction

  // Decode the token against the current stack
  always_comb begin
    is_bin = 1'b0;
    is_not = 1'b0;
    case (mode_r)
      MODE_EQ, MODE_AND, MODE_OR, MODE_ADD, MODE_SUB,
      MODE_MUL, MODE_DIV, MODE_MOD: is_bin = 1'b1;
      MODE_NOT:                     is_not = 1'b1;
      default:                      is_bin = 1'b0;
    endcase
    is_push = !is_bin && !is_not;
    sp_m1   = sp - SP_W'(1);
    sp_m2   = sp - SP_W'(2);
    under   = (is_bin && (sp < SP_W'(2))) || (is_not && (sp == '0));
    over    = is_push && (sp >= SP_W'(STACK_DEPTH));
    divzero = ((mode_r == MODE_DIV) || (mode_r == MODE_MOD)) && !under && (top == '0);
    if (under) begin
      st = ST_UNDER;
    end else if (over) begin
      st = ST_OVER;
    end else if (divzero) begin
      st = ST_DIVZERO;
    end else begin
      st = ST_OK;
    end
    ok = (st == ST_OK);
    if (is_push) begin
      sp_new = sp + SP_W'(1);
      wr_idx = sp[IDX_W-1:0];
    end else if (is_not) begin
      sp_new = sp;
      wr_idx = sp_m1[IDX_W-1:0];
    end else begin
      sp_new = sp_m1;
      wr_idx = sp_m2[IDX_W-1:0];
    end
    top_new = ok ? res : top;
  end

  // Single-cycle operations; a is the entry below the top, b is the top
  always_comb begin
    case (mode_r)
      MODE_LITERAL: alu = lit_r;
      MODE_EQ:      alu = DATA_WIDTH'(rdata == top);
      MODE_AND:     alu = DATA_WIDTH'((rdata != '0) && (top != '0));
      MODE_OR:      alu = DATA_WIDTH'((rdata != '0) || (top != '0));
      MODE_NOT:     alu = DATA_WIDTH'(top == '0);
      MODE_ADD:     alu = rdata + top;
      MODE_SUB:     alu = rdata - top;
      default:      alu = '0;
    endcase
  end

  assign stat.use_mul  = (mode_r == MODE_MUL) && !under;
  assign stat.use_div  = ((mode_r == MODE_DIV) || (mode_r == MODE_MOD)) && !under && !divzero;
  assign stat.mul_done = mul_done;
  assign stat.div_done = div_done;

  pse_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a       (rdata),
    .b       (top),
    .product (mul_p),
    .done    (mul_done)
  );

  pse_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (rdata),
    .divisor   (top),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  // Stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      rdata <= mem[sp_m2[IDX_W-1:0]];
    end
    if (cmd.commit && ok) begin
      mem[wr_idx] <= res;
    end
  end

  // Stack pointer; empty the stack after the last token
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        sp <= '0;
      end else if (ok) begin
        sp <= sp_new;
      end
    end
  end

  // Token capture, result, top-of-stack and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode;
      lit_r  <= lit_r_in(literal_value);
      last_r <= last_token;
    end
    if (cmd.exec) begin
      res <= alu;
    end else if (cmd.take_mul) begin
      res <= mul_p;
    end else if (cmd.take_div) begin
      res <= (mode_r == MODE_DIV) ? div_q : div_r;
    end
    if (cmd.commit) begin
      top             <= top_new;
      status          <= st;
      expression_done <= last_r;
      if (ok) begin
        stack_depth <= DEPTH_W'(sp_new);
        top_value   <= (sp_new == '0) ? '0 : LIT_W'(res);
      end else begin
        stack_depth <= DEPTH_W'(sp);
        top_value   <= (sp == '0) ? '0 : LIT_W'(top);
      end
    end
  end

endmodule

// File: design/pse_ctrl.sv
// Evaluator controller: sequences fetch, execute, multiply/divide wait and commit,
// and owns both handshakes. Uses pse_pkg command and status structs.
`timescale 1ns / 1ps

module pse_ctrl import pse_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Decode commands from the state
  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.rd_a      = (state == S_FETCH);
    cmd.exec      = (state == S_EXEC);
    cmd.mul_start = (state == S_EXEC) && stat.use_mul;
    cmd.div_start = (state == S_EXEC) && stat.use_div && !stat.use_mul;
    cmd.take_mul  = (state == S_MUL) && stat.mul_done;
    cmd.take_div  = (state == S_DIV) && stat.div_done;
    cmd.commit    = (state == S_COMMIT) && out_free;
  end

  // Hold state and the output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: state <= S_EXEC;
        S_EXEC: begin
          if (stat.use_mul) begin
            state <= S_MUL;
          end else if (stat.use_div) begin
            state <= S_DIV;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_MUL: begin
          if (stat.mul_done) begin
            state <= S_COMMIT;
          end
        end
        S_DIV: begin
          if (stat.div_done) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/postfix_stack_evaluator.sv
// Channel   Dir  Handshake      Payload
// token     in   valid/ready    mode, literal_value, last_token
// result    out  valid/ready    top_value, stack_depth, status, expression_done
//
// One token at a time. Push, not, eq, and, or, add, sub and all error cases go from
// accept through fetch and execute to commit; mul also waits on the four-step shared
// multiplier, div and mod on the divider (one quotient bit per cycle).
// The next token is accepted in the cycle after the result is loaded into the output
// register, so a stalled result blocks only after one further token.
// Synchronous reset empties the stack; memory contents are not cleared.
`timescale 1ns / 1ps

module postfix_stack_evaluator import pse_pkg::*; (
  input logic         clk,
  input logic         rst,
  pse_token_if.sink   token,
  pse_result_if.source result
);

  cmd_t     cmd;
  dp_stat_t stat;

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (token.valid),
    .in_ready  (token.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pse_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .mode            (token.mode),
    .literal_value   (token.literal_value),
    .last_token      (token.last_token),
    .top_value       (result.top_value),
    .stack_depth     (result.stack_depth),
    .status          (result.status),
    .expression_done (result.expression_done)
  );

`ifndef NO_ASSERTIONS
  // An empty stack reports a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.stack_depth == '0) |-> (result.top_value == '0))
    else $error("empty stack with nonzero top");

  // Only one token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    token.valid && token.ready |=> !token.ready)
    else $error("token accepted while busy");

  // Overflow only on a full stack
  a_over_full: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_OVER) |->
    (result.stack_depth == DEPTH_W'(STACK_DEPTH)))
    else $error("overflow reported below full depth");

  // Underflow only with fewer than two entries
  a_under_low: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_UNDER) |-> (result.stack_depth < DEPTH_W'(2)))
    else $error("underflow reported with enough operands");

  // Commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result.valid || result.ready))
    else $error("result overwritten");
`endif

endmodule
